/* src/sprh_pkg.sv */
// Shared types, constants and register codes for the sensor poll scheduler.
`timescale 1ns / 1ps

package sprh_pkg;

    // Slot arrangement
    localparam int          NUM_SLOTS       = 5;
    localparam logic [2:0]  LONG_SLOT       = 3'd4;
    localparam logic [2:0]  NO_MATCH        = 3'd5;
    localparam logic [4:0]  SHORT_READ      = 5'd10;
    localparam logic [4:0]  LONG_READ       = 5'd20;

    // Period handling
    localparam logic [15:0] MAX_PERIOD      = 16'd600;
    localparam logic [15:0] PERIOD_SCALE    = 16'd100;
    localparam logic [15:0] DEF_PERIOD      = 16'd1;

    // Default health threshold
    localparam int          DEF_FAULT_LIMIT = 3;

    // Configuration port geometry
    localparam int          CFG_ADDR_W      = 5;
    localparam int          CFG_DATA_W      = 32;

    // Divider geometry: 32-bit dividend, interval below 2^20
    localparam int          DIV_NUM_W       = 32;
    localparam int          DIV_DEN_W       = 20;
    localparam int          DIV_STEP_W      = 6;
    localparam logic [5:0]  QUO_STEPS       = 6'd16;
    localparam logic [5:0]  REM_STEPS       = 6'd32;

    // Register indexes on the configuration port (byte address / 4)
    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_PERIOD = 3'd1,
        REG_ADDR0  = 3'd2,
        REG_ADDR1  = 3'd3,
        REG_ADDR2  = 3'd4,
        REG_ADDR3  = 3'd5,
        REG_ADDR4  = 3'd6
    } t_reg_idx;

    // One tick
    typedef struct packed {
        logic [31:0] tick_time;
        logic        reply_valid;
        logic [7:0]  reply_addr;
    } t_in_item;

    // One tick result
    typedef struct packed {
        logic        poll_issued;
        logic [7:0]  poll_addr;
        logic [4:0]  poll_count;
        logic [2:0]  poll_slot;
        logic [2:0]  reply_slot;
        logic [4:0]  healthy_flags;
    } t_out_item;

    // Divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  dividend;
        logic [DIV_DEN_W-1:0]  divisor;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIV_NUM_W-1:0]  quotient;
        logic [DIV_DEN_W-1:0]  remainder;
    } t_div_rsp;

endpackage

/* src/sprh_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sprh_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sprh_pkg::t_div_req i_req,
    output sprh_pkg::t_div_rsp o_rsp
);
    import sprh_pkg::*;

    logic [DIV_NUM_W-1:0]  r_num, n_num;
    logic [DIV_DEN_W-1:0]  r_rem, n_rem;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIV_DEN_W:0]    w_trial;
    logic                  w_ge;

    // One shift-compare-subtract step
    always_comb begin
        w_trial = {r_rem, r_num[DIV_NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? DIV_DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DIV_DEN_W-1:0];
        n_num   = {r_num[DIV_NUM_W-2:0], w_ge};
    end

    // Control: load on start, count the steps down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_num;
    assign o_rsp.remainder = r_rem;

    // A new operation never starts over one in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    // Completion follows the last step
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished operation");

endmodule

/* src/sensor_poll_round_robin_health.sv */
// Top level of the round-robin sensor poll scheduler with per-slot health.
//
// Usage: one input transaction per 10 ms tick carries the tick time and an
// optional reply address. Each tick yields exactly one result transaction:
// the poll command (if any), the slot matched by the reply and the health
// flags. Both channels use valid/stall; a transaction moves on a rising edge
// with valid high and stall low. Configuration (enable mask, period, slot
// addresses) is written through the APB-style port at byte address 4*index.
// The user must write it only while no tick is in flight; the block does
// not enforce this. pready is always high. With at least one slot enabled
// a tick runs through the shared one-bit-per-cycle divider (16 steps for
// the interval quotient, 32 steps for the time remainder), then the apply
// and done states. With no slot enabled the divider is skipped.
// One tick is processed at a time; o_in_stall is high while it is in work.
// A finished result sits in the output register; the next tick may be taken
// and worked on while it waits, and a stalled receiver holds it unchanged.
// Reset: mask 0, period 1, addresses 0, fault counters at the limit, rank 0.
`timescale 1ns / 1ps

module sensor_poll_round_robin_health #(
    parameter int FAULT_LIMIT = sprh_pkg::DEF_FAULT_LIMIT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  sprh_pkg::t_in_item                i_in_data,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sprh_pkg::t_out_item               o_out_data,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sprh_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sprh_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sprh_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import sprh_pkg::*;

    localparam logic [7:0] FL = FAULT_LIMIT[7:0];

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_QUO   = 5'b00010,
        ST_REM   = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    // Configuration registers
    logic [4:0]  r_mask;
    logic [15:0] r_period;
    logic [7:0]  r_addr [NUM_SLOTS];

    // Scheduler state
    logic [2:0]  r_rank, n_rank;
    logic [7:0]  r_ctr  [NUM_SLOTS];
    logic [7:0]  n_ctr  [NUM_SLOTS];

    // Sequencer and working registers
    t_state      r_state;
    t_in_item    r_item;
    logic        r_hit;
    t_out_item   r_res, n_res;
    t_out_item   r_out;
    logic        r_out_valid;

    // Divider connection
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;

    logic        w_cfg_wr;
    logic        w_accept;
    logic [2:0]  w_slot_cnt;
    logic [9:0]  w_period;
    logic [15:0] w_scaled;
    logic [19:0] w_interval;
    logic [31:0] w_time10;
    logic [4:0]  w_health;

    // Small modulo for rank wrap: both operands at most five
    function automatic logic [2:0] mod_small(input logic [2:0] a, input logic [2:0] b);
        logic [2:0] r;
        r = a;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (r >= b) r = r - b;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_period <= DEF_PERIOD;
            for (int s = 0; s < NUM_SLOTS; s++) r_addr[s] <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[CFG_ADDR_W-1:2])
                REG_ENABLE: r_mask    <= pwdata[4:0];
                REG_PERIOD: r_period  <= pwdata[15:0];
                REG_ADDR0:  r_addr[0] <= pwdata[7:0];
                REG_ADDR1:  r_addr[1] <= pwdata[7:0];
                REG_ADDR2:  r_addr[2] <= pwdata[7:0];
                REG_ADDR3:  r_addr[3] <= pwdata[7:0];
                REG_ADDR4:  r_addr[4] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[CFG_ADDR_W-1:2])
            REG_ENABLE: prdata = {27'd0, r_mask};
            REG_PERIOD: prdata = {16'd0, r_period};
            REG_ADDR0:  prdata = {24'd0, r_addr[0]};
            REG_ADDR1:  prdata = {24'd0, r_addr[1]};
            REG_ADDR2:  prdata = {24'd0, r_addr[2]};
            REG_ADDR3:  prdata = {24'd0, r_addr[3]};
            REG_ADDR4:  prdata = {24'd0, r_addr[4]};
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Operand preparation
    always_comb begin
        w_slot_cnt = '0;
        for (int s = 0; s < NUM_SLOTS; s++) w_slot_cnt = w_slot_cnt + {2'b0, r_mask[s]};
    end

    assign w_period   = (r_period == 16'd0 || r_period > MAX_PERIOD) ? 10'd1 : r_period[9:0];
    assign w_scaled   = 16'({6'd0, w_period} * PERIOD_SCALE);
    // quotient times ten: (q << 3) + (q << 1), both terms at full 20 bits
    assign w_interval = {1'b0, w_div_rsp.quotient[15:0], 3'b0}
                      + {3'b0, w_div_rsp.quotient[15:0], 1'b0};
    // tick time times ten, wrapped to 32 bits
    assign w_time10   = 32'({r_item.tick_time, 3'b0} + {r_item.tick_time, 1'b0});

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    // Divider requests: interval quotient on accept, time remainder afterwards
    always_comb begin
        w_div_req = '0;
        if (w_accept && w_slot_cnt != 3'd0) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = {w_scaled, 16'd0};
            w_div_req.divisor  = 20'(w_slot_cnt);
            w_div_req.steps    = QUO_STEPS;
        end else if (r_state == ST_QUO && w_div_rsp.done) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = w_time10;
            w_div_req.divisor  = w_interval;
            w_div_req.steps    = REM_STEPS;
        end
    end

    sprh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------------------------------------------------------
    // Poll selection, counter update and reply matching
    always_comb begin
        logic [2:0] rk;
        logic       found;
        logic       matched;
        rk      = '0;
        found   = 1'b0;
        matched = 1'b0;
        n_rank  = r_rank;
        n_res   = r_res;
        for (int s = 0; s < NUM_SLOTS; s++) n_ctr[s] = r_ctr[s];

        if (r_hit) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (!found) begin
                    if (r_mask[s]) begin
                        if (rk == r_rank) begin
                            found             = 1'b1;
                            n_res.poll_issued = 1'b1;
                            n_res.poll_addr   = r_addr[s];
                            n_res.poll_slot   = 3'(s);
                            n_res.poll_count  = (3'(s) == LONG_SLOT) ? LONG_READ : SHORT_READ;
                            n_ctr[s]          = (r_ctr[s] >= FL - 8'd1) ? FL
                                                                        : r_ctr[s] + 8'd1;
                        end else begin
                            rk = rk + 3'd1;
                        end
                    end else begin
                        n_ctr[s] = 8'hFF;
                    end
                end
            end
            n_rank = mod_small(3'(r_rank + 3'd1), w_slot_cnt);
        end

        // reply handled after the poll; lowest matching slot wins
        if (r_item.reply_valid) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (!matched && r_addr[s] == r_item.reply_addr) begin
                    matched          = 1'b1;
                    n_ctr[s]         = 8'd0;
                    n_res.reply_slot = 3'(s);
                end
            end
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) w_health[s] = (r_ctr[s] < FL);
    end

    // ---------------------------------------------------------------
    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rank      <= '0;
            for (int s = 0; s < NUM_SLOTS; s++) r_ctr[s] <= FL;
        end else begin
            // output register: load a finished result, or empty on a take
            if (r_state == ST_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= (w_slot_cnt == 3'd0) ? ST_DONE : ST_QUO;
                    end
                end
                ST_QUO: begin
                    if (w_div_rsp.done) r_state <= ST_REM;
                end
                ST_REM: begin
                    if (w_div_rsp.done) r_state <= ST_APPLY;
                end
                ST_APPLY: begin
                    r_rank <= n_rank;
                    for (int s = 0; s < NUM_SLOTS; s++) r_ctr[s] <= n_ctr[s];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Working payload: tick, hit flag, partial result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
            r_hit  <= 1'b0;
            r_res  <= '{1'b0, 8'd0, 5'd0, 3'd0, NO_MATCH, 5'd0};
        end
        if (r_state == ST_REM && w_div_rsp.done) begin
            r_hit <= (w_div_rsp.remainder == '0);
        end
        if (r_state == ST_APPLY) begin
            r_res <= n_res;
        end
        if (r_state == ST_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out <= '{r_res.poll_issued, r_res.poll_addr, r_res.poll_count,
                       r_res.poll_slot, r_res.reply_slot, w_health};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------
    // Checks
    a_read_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.poll_issued |->
            o_out_data.poll_count == ((o_out_data.poll_slot == LONG_SLOT) ? LONG_READ
                                                                          : SHORT_READ))
        else $error("poll length does not match polled slot");

    a_quiet_no_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.poll_issued |->
            o_out_data.poll_addr == 8'd0 && o_out_data.poll_count == 5'd0 &&
            o_out_data.poll_slot == 3'd0)
        else $error("poll fields set without a poll");

    a_rank_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && $past(r_state) == ST_APPLY && $past(r_hit) |->
            r_rank < w_slot_cnt)
        else $error("round-robin rank not below enabled count");

    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_QUO || r_state == ST_REM))
        else $error("divider finished outside a divide step");

endmodule

/* bench/sensor_poll_round_robin_health_tb.sv */
// Self-checking testbench for the round-robin sensor poll scheduler with per-slot health.
`timescale 1ns / 1ps

module sensor_poll_round_robin_health_tb;
    import sprh_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          FAULT_LIMIT = DEF_FAULT_LIMIT;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE_CYC  = 60;
    localparam int          NUM_PHASES  = 40;
    localparam int          PHASE_ITEMS = 46;
    localparam int          DIR_ROWS    = 35;
    // index with no register behind it, writes must be dropped
    localparam logic [2:0]  REG_UNUSED  = 3'd7;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    // one line of the directed plan: a register write or a tick
    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [31:0] wval;
        t_in_item    tick;
        logic        typed;
        t_out_item   want;
    } t_plan_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_in_item                i_in_data;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_out_item               o_out_data;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    // shadow registers and scheduler state
    logic [4:0]  cfg_mask;
    logic [15:0] cfg_period;
    logic [7:0]  cfg_addr [NUM_SLOTS];
    logic [2:0]  slot_rank;
    logic [7:0]  fault_cnt [NUM_SLOTS];

    t_out_item   due_results [$];
    t_out_item   head_result;
    int          err_cnt      = 0;
    int          cycle_cnt    = 0;
    int          src_idle_pct = 0;
    int          out_stall_pct = 0;

    // directed plan: typed results only where obvious
    t_plan_row dir_plan [DIR_ROWS] = '{
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'h0000_0000, 1'b1, 8'h00}, 1'b1,
          '{1'b0, 8'h00, 5'd0, 3'd0, NO_MATCH, 5'b00000}},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'hFFFF_FFFF, 1'b1, 8'hFF}, 1'b1,
          '{1'b0, 8'h00, 5'd0, 3'd0, NO_MATCH, 5'b00000}},
        '{ROW_WRITE, REG_ADDR0,  32'h10, '0, 1'b0, '0},
        '{ROW_WRITE, REG_ADDR1,  32'h22, '0, 1'b0, '0},
        '{ROW_WRITE, REG_ADDR2,  32'h22, '0, 1'b0, '0},
        '{ROW_WRITE, REG_ADDR3,  32'hFF, '0, 1'b0, '0},
        '{ROW_WRITE, REG_ADDR4,  32'h00, '0, 1'b0, '0},
        '{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, '0, 1'b0, '0},
        '{ROW_WRITE, REG_PERIOD, 32'd1,  '0, 1'b0, '0},
        '{ROW_WRITE, REG_ENABLE, 32'h1F, '0, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd0, 1'b0, 8'h00}, 1'b1,
          '{1'b1, 8'h10, SHORT_READ, 3'd0, NO_MATCH, 5'b00000}},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd20, 1'b1, 8'h10}, 1'b1,
          '{1'b1, 8'h22, SHORT_READ, 3'd1, 3'd0, 5'b00001}},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd40, 1'b1, 8'h22}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd60, 1'b1, 8'h00}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd80, 1'b0, 8'h00}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd81, 1'b1, 8'h55}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'hFFFF_FFFF, 1'b1, 8'hFF}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd100, 1'b0, 8'h00}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd120, 1'b0, 8'h00}, 1'b0, '0},
        // shrink the mask under a high rank: no poll, disabled slots marked
        '{ROW_WRITE, REG_ENABLE, 32'h02, '0, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd0, 1'b0, 8'h00}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd100, 1'b1, 8'h22}, 1'b0, '0},
        // period zero falls back to one second
        '{ROW_WRITE, REG_PERIOD, 32'd0, '0, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd300, 1'b0, 8'h00}, 1'b0, '0},
        '{ROW_WRITE, REG_PERIOD, 32'd600, '0, 1'b0, '0},
        '{ROW_WRITE, REG_ENABLE, 32'h10, '0, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd60000, 1'b0, 8'h00}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd59999, 1'b1, 8'hFF}, 1'b0, '0},
        '{ROW_WRITE, REG_PERIOD, 32'd601, '0, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd100, 1'b0, 8'h00}, 1'b0, '0},
        '{ROW_WRITE, REG_PERIOD, 32'hFFFF, '0, 1'b0, '0},
        '{ROW_WRITE, REG_ENABLE, 32'h1F, '0, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd20, 1'b1, 8'h10}, 1'b0, '0},
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'd429496730, 1'b1, 8'h33}, 1'b0, '0},
        // time*10 wraps to exactly zero
        '{ROW_TICK,  REG_ENABLE, 32'd0, '{32'h8000_0000, 1'b0, 8'h00}, 1'b0, '0}
    };

    sensor_poll_round_robin_health #(
        .FAULT_LIMIT (FAULT_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run-away guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // poll spacing in 10 ms units of time*10; zero when no slot is enabled
    function automatic int unsigned poll_interval();
        int unsigned n_en;
        int unsigned per;
        n_en = $countones(cfg_mask);
        per  = 32'(cfg_period);
        if (per == 0 || per > MAX_PERIOD)
            per = 32'(DEF_PERIOD);
        if (n_en == 0)
            return 0;
        return (int'(PERIOD_SCALE) * per / n_en) * 10;
    endfunction

    // scheduler prediction for one tick, updates rank and fault counters
    function automatic t_out_item schedule_tick(input t_in_item tk);
        t_out_item   res;
        int unsigned ivl;
        int unsigned rnk;
        logic [2:0]  sel;
        logic [31:0] t10;
        bit          hit;
        bit          matched;
        res            = '0;
        res.reply_slot = NO_MATCH;
        ivl            = poll_interval();
        rnk            = 0;
        sel            = '0;
        hit            = 1'b0;
        matched        = 1'b0;
        if (ivl != 0) begin
            t10 = tk.tick_time * 32'd10;
            if (t10 % ivl == 0) begin
                // walk enabled slots to the current rank, marking disabled ones
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (!hit) begin
                        if (cfg_mask[s]) begin
                            if (rnk == slot_rank) begin
                                hit = 1'b1;
                                sel = 3'(s);
                            end else begin
                                rnk++;
                            end
                        end else begin
                            fault_cnt[s] = 8'd255;
                        end
                    end
                end
                if (hit) begin
                    res.poll_issued = 1'b1;
                    res.poll_addr   = cfg_addr[sel];
                    res.poll_count  = (sel == LONG_SLOT) ? LONG_READ : SHORT_READ;
                    res.poll_slot   = sel;
                    if (fault_cnt[sel] >= FAULT_LIMIT - 1)
                        fault_cnt[sel] = 8'(FAULT_LIMIT);
                    else
                        fault_cnt[sel] = fault_cnt[sel] + 8'd1;
                end
                slot_rank = 3'((slot_rank + 1) % $countones(cfg_mask));
            end
            // reply: lowest matching slot wins, mask not consulted
            if (tk.reply_valid) begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (!matched && cfg_addr[s] == tk.reply_addr) begin
                        fault_cnt[s]   = 8'd0;
                        res.reply_slot = 3'(s);
                        matched        = 1'b1;
                    end
                end
            end
        end
        for (int s = 0; s < NUM_SLOTS; s++)
            res.healthy_flags[s] = (fault_cnt[s] < FAULT_LIMIT);
        return res;
    endfunction

    // random tick, mostly on poll boundaries
    function automatic t_in_item make_tick();
        t_in_item    tk;
        int unsigned ivl;
        int unsigned step;
        ivl = poll_interval();
        if (ivl != 0 && $urandom_range(0, 99) < 70) begin
            step         = ivl / 10;
            tk.tick_time = $urandom_range(0, 32'd429496729 / step) * step;
        end else begin
            tk.tick_time = $urandom;
        end
        tk.reply_valid = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 60)
            tk.reply_addr = cfg_addr[3'($urandom_range(0, NUM_SLOTS - 1))];
        else
            tk.reply_addr = 8'($urandom_range(0, 255));
        return tk;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // result channel check
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $error("result transaction with none expected");
                err_cnt++;
            end else begin
                head_result = due_results.pop_front();
                check_field("poll_issued",   head_result.poll_issued,   o_out_data.poll_issued);
                check_field("poll_addr",     head_result.poll_addr,     o_out_data.poll_addr);
                check_field("poll_count",    head_result.poll_count,    o_out_data.poll_count);
                check_field("poll_slot",     head_result.poll_slot,     o_out_data.poll_slot);
                check_field("reply_slot",    head_result.reply_slot,    o_out_data.reply_slot);
                check_field("healthy_flags", head_result.healthy_flags,
                            o_out_data.healthy_flags);
            end
        end
    end

    // called at a falling edge, returns at the next falling edge after acceptance
    task automatic send_tick(input t_in_item tk, input logic typed, input t_out_item want);
        t_out_item pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tk;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pred = schedule_tick(tk);
        due_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // hold the sender until every outstanding result has been taken
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // setup and access phase; the shadow copy follows the write
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_ENABLE: cfg_mask   = val[4:0];
            REG_PERIOD: cfg_period = val[15:0];
            REG_ADDR0, REG_ADDR1, REG_ADDR2, REG_ADDR3, REG_ADDR4:
                cfg_addr[idx - REG_ADDR0] = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // new random settings for a phase, extremes included
    task automatic pick_settings();
        logic [31:0] pval;
        logic [31:0] mval;
        logic [7:0]  aval;
        case ($urandom_range(0, 7))
            0: pval = 32'd0;
            1: pval = 32'd1;
            2: pval = 32'd600;
            3: pval = 32'd601;
            4: pval = 32'hFFFF;
            5: pval = $urandom_range(2, 10);
            6: pval = $urandom_range(1, 600);
            default: pval = $urandom & 32'hFFFF;
        endcase
        cfg_write(REG_PERIOD, pval);
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if ($urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 1))
                    aval = 8'($urandom_range(0, 255));
                else
                    aval = cfg_addr[3'($urandom_range(0, NUM_SLOTS - 1))];
                cfg_write(3'(REG_ADDR0 + s), {24'd0, aval});
            end
        end
        case ($urandom_range(0, 9))
            0:       mval = 32'h00;
            1:       mval = 32'h1F;
            default: mval = $urandom_range(1, 31);
        endcase
        cfg_write(REG_ENABLE, mval);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cfg_mask   = '0;
        cfg_period = DEF_PERIOD;
        slot_rank  = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            cfg_addr[s]  = 8'd0;
            fault_cnt[s] = 8'(FAULT_LIMIT);
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed plan
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_plan[r].kind == ROW_WRITE) begin
                drain();
                cfg_write(dir_plan[r].reg_idx, dir_plan[r].wval);
            end else begin
                send_tick(dir_plan[r].tick, dir_plan[r].typed, dir_plan[r].want);
            end
        end

        // random phases, each under fresh settings and one of four idling patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            pick_settings();
            case (ph % 4)
                0: begin src_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin src_idle_pct = 64; out_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  out_stall_pct = 64; end
                default: begin src_idle_pct = 27; out_stall_pct = 27; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_tick(make_tick(), 1'b0, '0);
        end

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0 && due_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
